// ===== hw/rtl/mfd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared widths, command codes, register indexes and types of the
// monochrome framebuffer drawing engine.
// ----------------------------------------------------------------------------
package mfd_pkg;

   localparam int POS_W  = 10;         // pixel column / row fields
   localparam int BITS_W = 16;         // span pattern
   localparam int PAT_IW = 4;          // index into the span pattern
   localparam int LEN_W  = 5;          // span length field
   localparam int RIDX_W = 11;         // read index field
   localparam int DIM_W  = 8;          // width / height registers
   localparam int COL_W  = 12;         // pixel column reached by a span
   localparam int BCOL_W = COL_W - 3;  // byte column reached by a span
   localparam int NB_W   = 3;          // bytes touched by one span
   localparam int CSR_W  = 2;          // register index

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_PLOT  = 2'd1;
   localparam logic [1:0] OP_SPAN  = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   localparam logic [CSR_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_W-1:0] CSR_INVERT = 2'd2;

   localparam logic [DIM_W-1:0]  WIDTH_RST  = 8'd128;
   localparam logic [DIM_W-1:0]  HEIGHT_RST = 8'd128;
   localparam logic [7:0]        FILL_ONES  = 8'hFF;
   localparam logic [7:0]        FILL_ZEROS = 8'h00;
   localparam logic [BITS_W-1:0] PLOT_BITS  = 16'h8000;
   localparam logic [LEN_W-1:0]  PLOT_LEN   = 5'd1;

   typedef struct packed {
      logic [POS_W-1:0]  pos_x;
      logic              color;    // already passed through the invert setting
      logic [BITS_W-1:0] bits;
      logic [LEN_W-1:0]  len;      // already saturated
      logic              opaque;
   } span_cmd_type;

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_CLEAR     = 6'b000010,
      ST_SPAN_RD   = 6'b000100,
      ST_SPAN_WR   = 6'b001000,
      ST_READ      = 6'b010000,
      ST_READ_DATA = 6'b100000
   } state_type;

endpackage
`default_nettype wire

// ===== hw/rtl/mono_framebuffer_draw.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mono_framebuffer_draw
// 1-bit-per-pixel framebuffer with clear, plot, span and byte read commands.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the req_ channel (valid/ready); req_op selects clear,
//   plot, span or read. Only a read returns a transfer on the rsp_ channel,
//   carrying the store byte (MSB is the leftmost pixel). The csr_ port writes
//   the active width, height and invert setting at any edge with csr_write
//   high; write it only while no command is in flight.
//   Store: the store is a single-port-read, single-port-write memory with a
//   registered read, and each touched byte is read, merged and written back,
//   the read first and the write after it. A span covers up to 3 bytes for
//   16 pixels; a plot or span that lies wholly off the active rows or covers
//   no byte touches no store byte. A read in range fetches the store byte and
//   then registers it; a clear writes (width*height)/8 bytes, one byte per cycle.
//   req_ready is high only between commands.
//   The rsp_ channel has an output register; draw commands proceed while a
//   read result waits. A read that finds the output register still full
//   holds until the receiver takes it.
//   Reset restores width 128, height 128, no inversion; the store contents
//   are undefined until drawn or cleared, and no clearing pass runs.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw import mfd_pkg::*; #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128,
   parameter int SPAN_MAX   = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_op,
   input  wire logic [POS_W-1:0]  req_pos_x,
   input  wire logic [POS_W-1:0]  req_pos_y,
   input  wire logic              req_color,
   input  wire logic [BITS_W-1:0] req_span_bits,
   input  wire logic [LEN_W-1:0]  req_span_length,
   input  wire logic              req_opaque,
   input  wire logic [RIDX_W-1:0] req_read_index,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic      [7:0]        rsp_read_byte,
   input  wire logic              csr_write,
   input  wire logic [CSR_W-1:0]  csr_index,
   input  wire logic [DIM_W-1:0]  csr_data
);

   localparam int DEPTH = (MAX_WIDTH / 8) * MAX_HEIGHT;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = IDX_W + 1;
   localparam int SUM_W = ((IDX_W > BCOL_W) ? IDX_W : BCOL_W) + 1;

   // configuration
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic             invert_ff, invert_in;

   // sequencer
   state_type         state_ff, state_in;
   span_cmd_type      cmd_ff, cmd_in;
   logic [IDX_W-1:0]  row_base_ff, row_base_in;
   logic [BCOL_W-1:0] bcol_ff, bcol_in;
   logic [NB_W-1:0]   left_ff, left_in;
   logic [BCOL_W-1:0] wr_bcol_ff, wr_bcol_in;
   logic [IDX_W-1:0]  wr_addr_ff, wr_addr_in;
   logic              wr_ok_ff, wr_ok_in;
   logic [CNT_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [CNT_W-1:0]  clr_size_ff, clr_size_in;
   logic [7:0]        fill_ff, fill_in;
   logic [RIDX_W-1:0] ridx_ff, ridx_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;

   // combinational helpers
   logic                   accept;
   logic [DIM_W-1:0]       eff_w, eff_h;
   logic [DIM_W-4:0]       stride;
   logic [2*DIM_W-4:0]     row_prod;
   logic [2*DIM_W-1:0]     area;
   logic [CNT_W-1:0]       clr_size;
   logic                   y_ok;
   logic [LEN_W-1:0]       len_sat, len_cmd;
   logic [5:0]             nb_sum;
   logic [NB_W-1:0]        nb;
   logic [SUM_W-1:0]       addr_sum;
   logic                   issue;
   logic                   slot_free;
   logic                   ridx_ok;
   logic                   draw_color;

   // store ports
   logic             ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [7:0]       ram_wr_data, ram_rd_data;
   logic [7:0]       merged;

   // saturate the active size to the store geometry
   assign eff_w    = (width_ff > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_ff;
   assign eff_h    = (height_ff > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_ff;
   assign stride   = eff_w[DIM_W-1:3];
   assign row_prod = req_pos_y[DIM_W-1:0] * stride;
   assign area     = eff_w * eff_h;
   assign clr_size = (area[2*DIM_W-1:3] >= DEPTH) ? CNT_W'(DEPTH)
                                                  : CNT_W'(area[2*DIM_W-1:3]);
   assign y_ok     = req_pos_y < POS_W'(eff_h);

   assign len_sat  = (req_span_length > SPAN_MAX) ? LEN_W'(SPAN_MAX) : req_span_length;
   assign len_cmd  = (req_op == OP_PLOT) ? PLOT_LEN : len_sat;
   assign nb_sum   = 6'(req_pos_x[2:0]) + 6'(len_cmd) + 6'd7;
   assign nb       = nb_sum[5:3];

   assign draw_color = req_color ^ invert_ff;

   assign addr_sum  = SUM_W'(row_base_ff) + SUM_W'(bcol_ff);
   assign issue     = (state_ff == ST_SPAN_RD) || ((state_ff == ST_SPAN_WR) && (left_ff != '0));
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign ridx_ok   = ridx_ff < DEPTH;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // configuration writes; indexes past the list are dropped
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      invert_in = invert_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_WIDTH:  width_in  = csr_data;
            CSR_HEIGHT: height_in = csr_data;
            CSR_INVERT: invert_in = csr_data[0];
            default:    ;
         endcase
      end
   end

   // command sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      row_base_in  = row_base_ff;
      bcol_in      = bcol_ff;
      left_in      = left_ff;
      wr_bcol_in   = wr_bcol_ff;
      wr_addr_in   = wr_addr_ff;
      wr_ok_in     = wr_ok_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_size_in  = clr_size_ff;
      fill_in      = fill_ff;
      ridx_in      = ridx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;

      // read the next span byte, and hold its address for the write back
      if (issue) begin
         wr_addr_in = addr_sum[IDX_W-1:0];
         wr_ok_in   = addr_sum < DEPTH;
         wr_bcol_in = bcol_ff;
         bcol_in    = bcol_ff + 1'b1;
         left_in    = left_ff - 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in.pos_x  = req_pos_x;
               cmd_in.color  = draw_color;
               cmd_in.bits   = (req_op == OP_PLOT) ? PLOT_BITS : req_span_bits;
               cmd_in.len    = len_cmd;
               cmd_in.opaque = (req_op == OP_PLOT) ? 1'b0 : req_opaque;
               row_base_in   = IDX_W'(row_prod);
               bcol_in       = BCOL_W'(req_pos_x[POS_W-1:3]);
               left_in       = nb;
               fill_in       = draw_color ? FILL_ONES : FILL_ZEROS;
               clr_size_in   = clr_size;
               clr_cnt_in    = '0;
               ridx_in       = req_read_index;
               case (req_op)
                  OP_CLEAR: begin
                     if (clr_size != '0) begin
                        state_in = ST_CLEAR;
                     end
                  end
                  OP_PLOT, OP_SPAN: begin
                     // drop spans that lie wholly off the active rows or cover no byte
                     if (y_ok && (nb != '0)) begin
                        state_in = ST_SPAN_RD;
                     end
                  end
                  OP_READ: state_in = ST_READ;
                  default: ;
               endcase
            end
         end
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_in == clr_size_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_SPAN_RD: begin
            state_in = ST_SPAN_WR;
         end
         ST_SPAN_WR: begin
            if (left_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            // hold until the result register is free
            if (slot_free) begin
               if (ridx_ok) begin
                  state_in = ST_READ_DATA;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = FILL_ZEROS;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_READ_DATA: begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = ram_rd_data;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // store port selection
   assign ram_rd_en   = issue || ((state_ff == ST_READ) && slot_free && ridx_ok);
   assign ram_rd_addr = (state_ff == ST_READ) ? IDX_W'(ridx_ff) : addr_sum[IDX_W-1:0];
   assign ram_wr_en   = (state_ff == ST_CLEAR) || ((state_ff == ST_SPAN_WR) && wr_ok_ff);
   assign ram_wr_addr = (state_ff == ST_CLEAR) ? clr_cnt_ff[IDX_W-1:0] : wr_addr_ff;
   assign ram_wr_data = (state_ff == ST_CLEAR) ? fill_ff : merged;

   mfd_ram #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   mfd_merge u_merge (
      .cmd       (cmd_ff),
      .byte_col  (wr_bcol_ff),
      .eff_width (eff_w),
      .old_byte  (ram_rd_data),
      .new_byte  (merged)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RST;
         height_ff    <= HEIGHT_RST;
         invert_ff    <= 1'b0;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         invert_ff    <= invert_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      row_base_ff <= row_base_in;
      bcol_ff     <= bcol_in;
      left_ff     <= left_in;
      wr_bcol_ff  <= wr_bcol_in;
      wr_addr_ff  <= wr_addr_in;
      wr_ok_ff    <= wr_ok_in;
      clr_cnt_ff  <= clr_cnt_in;
      clr_size_ff <= clr_size_in;
      fill_ff     <= fill_in;
      ridx_ff     <= ridx_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_byte = rsp_byte_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/mfd_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mfd_ram
// Framebuffer byte store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mfd_ram #(
   parameter int DEPTH = 2048,
   parameter int IDX_W = 11
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire logic [7:0]       wr_data,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_addr,
   output logic      [7:0]       rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/mfd_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mfd_merge
// Merge the pixels of one span into one store byte, with clipping to the
// active width.
// ----------------------------------------------------------------------------
module mfd_merge import mfd_pkg::*; (
   input  wire span_cmd_type      cmd,
   input  wire logic [BCOL_W-1:0] byte_col,
   input  wire logic [DIM_W-1:0]  eff_width,
   input  wire logic [7:0]        old_byte,
   output logic      [7:0]        new_byte
);

   logic [COL_W-1:0] px  [8];
   logic [COL_W-1:0] rel [8];
   logic [7:0]       pat;
   logic [7:0]       drive;

   always_comb begin
      new_byte = old_byte;
      for (int b = 0; b < 8; b++) begin
         px[b]    = {byte_col, 3'(b)};
         rel[b]   = px[b] - COL_W'(cmd.pos_x);
         // pattern bits past the end of the pattern read as zero
         pat[b]   = (rel[b] < COL_W'(BITS_W)) && cmd.bits[~rel[b][PAT_IW-1:0]];
         drive[b] = (px[b] >= COL_W'(cmd.pos_x)) && (rel[b] < COL_W'(cmd.len))
                    && (px[b] < COL_W'(eff_width)) && (pat[b] || cmd.opaque);
         if (drive[b]) begin
            new_byte[7-b] = pat[b] ? cmd.color : ~cmd.color;
         end
      end
   end

endmodule
`default_nettype wire
